@@ sv/buzzer_tone_pattern_sequencer_unit_macros.svh @@
// Assertion macros for the buzzer tone pattern sequencer checks.
`ifndef BUZZER_TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btps check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BTPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btps check failed");

`endif

@@ sv/btps_pkg.sv @@
// Shared types, constants and tune tables of the buzzer tone pattern sequencer.
package btps_pkg;

    localparam int MODE_W       = 3;
    localparam int HZ_W         = 16;
    localparam int LEN_W        = 16;
    localparam int RELOAD_W     = 16;
    localparam int KIND_W       = 2;
    localparam int CLK_HZ_W     = 24;
    localparam int SEG_W        = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int DIV_W        = HZ_W + 1;
    localparam int ROM_AW       = 4;
    localparam int ROM_LEN_W    = 9;
    localparam int TUNE_DEFINED = 14;

    localparam logic [SEG_W-1:0]    SEG_MAX    = 15'd21845;
    localparam logic [CLK_HZ_W-1:0] CLK_HZ_RST = 24'd921600;
    localparam logic [HZ_W-1:0]     ERR_HZ_RST = 16'd2000;
    localparam logic [SEG_W-1:0]    SEG_RST    = 15'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_ONESHOT = 3'd1,
        MODE_ERROR   = 3'd2,
        MODE_MELODY  = 3'd3,
        MODE_STOP    = 3'd4
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDLE    = 2'd0,
        KIND_ONESHOT = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_MELODY  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CLOCK   = 2'd0,
        CFG_ERROR_TONE    = 2'd1,
        CFG_ERROR_SEGMENT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIVIDE,
        S_DELIVER
    } state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic div_start;
        logic div_load;
        logic load_out;
    } btps_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } btps_sts_t;

    function automatic logic [HZ_W-1:0] tune_pitch(input logic [ROM_AW-1:0] idx);
        logic [HZ_W-1:0] val;
        case (idx)
            4'd0:    val = 16'd392;
            4'd1:    val = 16'd523;
            4'd2:    val = 16'd659;
            4'd3:    val = 16'd784;
            4'd4:    val = 16'd1047;
            4'd5:    val = 16'd1319;
            4'd6:    val = 16'd1568;
            4'd7:    val = 16'd1319;
            4'd8:    val = 16'd415;
            4'd9:    val = 16'd523;
            4'd10:   val = 16'd622;
            4'd11:   val = 16'd831;
            4'd12:   val = 16'd1047;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [ROM_LEN_W-1:0] tune_len(input logic [ROM_AW-1:0] idx);
        logic [ROM_LEN_W-1:0] val;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: val = 9'd90;
            4'd6:    val = 9'd260;
            4'd7:    val = 9'd120;
            4'd8, 4'd9, 4'd10, 4'd11: val = 9'd90;
            4'd12:   val = 9'd300;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ sv/btps_if.sv @@
// Command and result channel interfaces of the buzzer tone pattern sequencer.
interface btps_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [btps_pkg::MODE_W-1:0] mode;
    logic [btps_pkg::HZ_W-1:0]   tone_hz;
    logic [btps_pkg::LEN_W-1:0]  length_ms;

    modport source (output valid, output mode, output tone_hz, output length_ms, input ready);
    modport sink   (input valid, input mode, input tone_hz, input length_ms, output ready);
endinterface

interface btps_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          tone_on;
    logic [btps_pkg::RELOAD_W-1:0] tone_reload;
    logic                          pattern_done;
    logic [btps_pkg::KIND_W-1:0]   active_pattern;

    modport source (output valid, output tone_on, output tone_reload, output pattern_done,
                    output active_pattern, input ready);
    modport sink   (input valid, input tone_on, input tone_reload, input pattern_done,
                    input active_pattern, output ready);
endinterface

@@ sv/btps_div.sv @@
// Restoring divider, one quotient bit per cycle, for the half period count.
module btps_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [btps_pkg::CLK_HZ_W-1:0] dividend,
    input  logic [btps_pkg::DIV_W-1:0]    divisor,
    output logic                          done,
    output logic [btps_pkg::CLK_HZ_W-1:0] quotient
);
    import btps_pkg::*;

    localparam int CNT_W = $clog2(CLK_HZ_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_HZ_W - 1);

    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [CLK_HZ_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;

    assign trial = {rem_reg, quo_reg[CLK_HZ_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[CLK_HZ_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[CLK_HZ_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/btps_dp.sv @@
// Datapath: configuration, pattern state, reload computation and result register.
module btps_dp #(
    parameter int TUNE_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  btps_pkg::btps_cmd_t             ctl,
    output btps_pkg::btps_sts_t             sts,
    input  logic                            cfg_we,
    input  logic [btps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [btps_pkg::MODE_W-1:0]     mode,
    input  logic [btps_pkg::HZ_W-1:0]       tone_hz,
    input  logic [btps_pkg::LEN_W-1:0]      length_ms,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic                            tone_on,
    output logic [btps_pkg::RELOAD_W-1:0]   tone_reload,
    output logic                            pattern_done,
    output logic [btps_pkg::KIND_W-1:0]     active_pattern
);
    import btps_pkg::*;

    localparam int NOTE_MAX = (TUNE_SLOTS < TUNE_DEFINED) ? TUNE_SLOTS : TUNE_DEFINED;
    localparam int NOTE_W   = $clog2(NOTE_MAX + 1);

    logic [CLK_HZ_W-1:0] clk_hz_reg;
    logic [HZ_W-1:0]     err_hz_reg;
    logic [SEG_W-1:0]    seg_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [HZ_W-1:0]     hz_reg;
    logic [LEN_W-1:0]    len_reg;

    kind_t               kind_reg, kind_next;
    logic [LEN_W-1:0]    elapsed_reg, elapsed_next;
    logic [LEN_W-1:0]    target_reg, target_next;
    logic                finished_reg, finished_next;
    logic [NOTE_W-1:0]   note_reg, note_next;
    logic                enable_reg, enable_next;
    logic [RELOAD_W-1:0] reload_reg;

    logic                out_valid_reg;
    logic                out_tone_reg;
    logic [RELOAD_W-1:0] out_reload_reg;
    logic                out_done_reg;
    logic [KIND_W-1:0]   out_kind_reg;

    logic [SEG_W-1:0]     seg;
    logic [LEN_W-1:0]     seg2;
    logic [LEN_W-1:0]     seg3;
    logic [LEN_W-1:0]     inc;
    logic [NOTE_W-1:0]    note_inc;
    logic [ROM_LEN_W-1:0] cur_len;
    logic [ROM_LEN_W-1:0] nxt_len;
    logic [HZ_W-1:0]      nxt_pitch;
    logic [HZ_W-1:0]      first_pitch;
    logic                 freq_set;
    logic [HZ_W-1:0]      freq_val;
    logic                 div_done;
    logic [CLK_HZ_W-1:0]  quotient;
    logic [RELOAD_W-1:0]  half;

    assign seg      = (seg_reg > SEG_MAX) ? SEG_MAX : seg_reg;
    assign seg2     = {seg, 1'b0};
    assign seg3     = seg2 + LEN_W'(seg);
    assign inc      = elapsed_reg + 1'b1;
    assign note_inc = note_reg + 1'b1;

    assign cur_len     = (int'(note_reg) < TUNE_SLOTS) ? tune_len(ROM_AW'(note_reg)) : '0;
    assign nxt_len     = (int'(note_inc) < TUNE_SLOTS) ? tune_len(ROM_AW'(note_inc)) : '0;
    assign nxt_pitch   = (int'(note_inc) < TUNE_SLOTS) ? tune_pitch(ROM_AW'(note_inc)) : '0;
    assign first_pitch = tune_pitch('0);

    always_comb
    begin
        kind_next     = kind_reg;
        elapsed_next  = elapsed_reg;
        target_next   = target_reg;
        finished_next = finished_reg;
        note_next     = note_reg;
        enable_next   = enable_reg;
        freq_set      = 1'b0;
        freq_val      = '0;
        unique case (mode_t'(mode_reg))
            MODE_TICK:
            begin
                case (kind_reg)
                    KIND_ONESHOT:
                    begin
                        elapsed_next = inc;
                        if (inc >= target_reg)
                        begin
                            enable_next   = 1'b0;
                            kind_next     = KIND_IDLE;
                            elapsed_next  = '0;
                            target_next   = '0;
                            finished_next = 1'b1;
                        end
                    end
                    KIND_ERROR:
                    begin
                        elapsed_next = inc;
                        if (inc == LEN_W'(seg))
                        begin
                            freq_set = 1'b1;
                        end
                        else if (inc == seg2)
                        begin
                            freq_set = 1'b1;
                            freq_val = err_hz_reg;
                        end
                        else if (inc >= seg3)
                        begin
                            enable_next   = 1'b0;
                            kind_next     = KIND_IDLE;
                            elapsed_next  = '0;
                            target_next   = '0;
                            finished_next = 1'b1;
                        end
                    end
                    KIND_MELODY:
                    begin
                        elapsed_next = inc;
                        if (inc >= LEN_W'(cur_len))
                        begin
                            note_next    = note_inc;
                            elapsed_next = '0;
                            if (nxt_len == '0)
                            begin
                                enable_next   = 1'b0;
                                kind_next     = KIND_IDLE;
                                target_next   = '0;
                                finished_next = 1'b1;
                            end
                            else
                            begin
                                freq_set = 1'b1;
                                freq_val = nxt_pitch;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_ONESHOT:
            begin
                kind_next     = KIND_ONESHOT;
                elapsed_next  = '0;
                target_next   = len_reg;
                finished_next = 1'b0;
                freq_set      = 1'b1;
                freq_val      = hz_reg;
            end
            MODE_ERROR:
            begin
                kind_next     = KIND_ERROR;
                elapsed_next  = '0;
                target_next   = seg3;
                finished_next = 1'b0;
                freq_set      = 1'b1;
                freq_val      = err_hz_reg;
            end
            MODE_MELODY:
            begin
                kind_next     = KIND_MELODY;
                elapsed_next  = '0;
                note_next     = '0;
                finished_next = 1'b0;
                freq_set      = 1'b1;
                freq_val      = first_pitch;
            end
            MODE_STOP:
            begin
                enable_next   = 1'b0;
                kind_next     = KIND_IDLE;
                elapsed_next  = '0;
                target_next   = '0;
                finished_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (freq_set && freq_val == '0)
        begin
            enable_next = 1'b0;
        end
    end

    btps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (clk_hz_reg),
        .divisor  ({freq_val, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    assign half = (|quotient[CLK_HZ_W-1:RELOAD_W]) ? '1 : quotient[RELOAD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLK_HZ_RST;
            err_hz_reg <= ERR_HZ_RST;
            seg_reg    <= SEG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIMER_CLOCK:   clk_hz_reg <= cfg_data;
                CFG_ERROR_TONE:    err_hz_reg <= cfg_data[HZ_W-1:0];
                CFG_ERROR_SEGMENT: seg_reg    <= cfg_data[SEG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            mode_reg <= mode;
            hz_reg   <= tone_hz;
            len_reg  <= length_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_IDLE;
            elapsed_reg  <= '0;
            target_reg   <= '0;
            finished_reg <= 1'b0;
            note_reg     <= '0;
            enable_reg   <= 1'b0;
            reload_reg   <= '0;
        end
        else if (ctl.exec)
        begin
            kind_reg     <= kind_next;
            elapsed_reg  <= elapsed_next;
            target_reg   <= target_next;
            finished_reg <= finished_next;
            note_reg     <= note_next;
            enable_reg   <= enable_next;
        end
        else if (ctl.div_load)
        begin
            reload_reg <= ~half + 1'b1;
            enable_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_tone_reg   <= enable_reg;
            out_reload_reg <= reload_reg;
            out_done_reg   <= finished_reg;
            out_kind_reg   <= kind_reg;
        end
    end

    assign sts.need_div = freq_set && (freq_val != '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || rsp_ready;

    assign rsp_valid      = out_valid_reg;
    assign tone_on        = out_tone_reg;
    assign tone_reload    = out_reload_reg;
    assign pattern_done   = out_done_reg;
    assign active_pattern = out_kind_reg;

endmodule

@@ sv/btps_ctrl.sv @@
// Controller state machine sequencing decode, divide and result transfer.
module btps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    output btps_pkg::btps_cmd_t ctl,
    input  btps_pkg::btps_sts_t sts
);
    import btps_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (cmd_valid)    state_next = S_EXEC;
            S_EXEC:    state_next = sts.need_div ? S_DIVIDE : S_DELIVER;
            S_DIVIDE:  if (sts.div_done) state_next = S_DELIVER;
            S_DELIVER: if (sts.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready     = 1'b0;
        ctl.take      = 1'b0;
        ctl.exec      = 1'b0;
        ctl.div_start = 1'b0;
        ctl.div_load  = 1'b0;
        ctl.load_out  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.take  = cmd_valid;
            end
            S_EXEC:
            begin
                ctl.exec      = 1'b1;
                ctl.div_start = sts.need_div;
            end
            S_DIVIDE:  ctl.div_load = sts.div_done;
            S_DELIVER: ctl.load_out = sts.out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/buzzer_tone_pattern_sequencer_unit.sv @@
// Top level of the buzzer tone pattern sequencer.
// Each command transfer yields one result transfer. A command is decoded in
// the EXEC state; when it sets a new nonzero frequency the reload value comes
// from a restoring divider that resolves one quotient bit per cycle over the
// 24-bit timer clock in the DIVIDE state. The result is loaded in the DELIVER
// state once the output register is free. The block holds one command at a
// time; a finished result waits in an output register while the next command
// is taken. Configuration writes belong between patterns, while no command is
// in flight.
module buzzer_tone_pattern_sequencer_unit #(
    parameter int TUNE_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    btps_cmd_if.sink                        cmd,
    btps_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [btps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import btps_pkg::*;

    btps_cmd_t ctl;
    btps_sts_t sts;

    btps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    btps_dp #(
        .TUNE_SLOTS (TUNE_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (cmd.mode),
        .tone_hz        (cmd.tone_hz),
        .length_ms      (cmd.length_ms),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .tone_on        (rsp.tone_on),
        .tone_reload    (rsp.tone_reload),
        .pattern_done   (rsp.pattern_done),
        .active_pattern (rsp.active_pattern)
    );

endmodule

@@ sv/btps_checker.sv @@
// Port-level assertion checker for the buzzer tone pattern sequencer, with bind.
`include "buzzer_tone_pattern_sequencer_unit_macros.svh"

module btps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          tone_on,
    input logic [btps_pkg::RELOAD_W-1:0] tone_reload,
    input logic                          pattern_done,
    input logic [btps_pkg::KIND_W-1:0]   active_pattern
);
    import btps_pkg::*;

    `BTPS_ASSERT_NEXT(a_busy_after_transfer, cmd_valid && cmd_ready, !cmd_ready)
    `BTPS_ASSERT_IMPL(a_idle_is_silent, rsp_valid && active_pattern == KIND_IDLE, !tone_on)
    `BTPS_ASSERT_IMPL(a_done_means_idle, rsp_valid && pattern_done, active_pattern == KIND_IDLE)
    `BTPS_ASSERT_NEXT(a_stalled_result_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(tone_on) && $stable(tone_reload) && $stable(pattern_done) && $stable(active_pattern))

endmodule

bind buzzer_tone_pattern_sequencer_unit btps_checker u_btps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .tone_on        (rsp.tone_on),
    .tone_reload    (rsp.tone_reload),
    .pattern_done   (rsp.pattern_done),
    .active_pattern (rsp.active_pattern)
);
